// File: src/mhd_pkg.sv
// Shared types and constants for the three-axis motion hit detector.
package mhd_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned AvgW      = 32;
  localparam int unsigned ThrW      = 16;
  localparam int unsigned WeightW   = 17;
  localparam int unsigned LockW     = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 17;

  localparam logic [ThrW-1:0]    ThrReset    = ThrW'(3500);
  localparam logic [WeightW-1:0] WeightReset = WeightW'(65470);
  localparam logic [WeightW-1:0] WeightOne   = WeightW'(65536);
  localparam logic [LockW-1:0]   LockReset   = LockW'(20);

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    RegThreshold = 2'd0,
    RegWeight    = 2'd1,
    RegLockout   = 2'd2
  } cfg_reg_e;

  // Settings that every lane reads
  typedef struct packed {
    logic [ThrW-1:0]    threshold;
    logic [WeightW-1:0] weight;     // already saturated to 1.0
    logic [LockW-1:0]   lockout;
  } lane_cfg_t;

  // One result beat
  typedef struct packed {
    logic hit_z;
    logic hit_y;
    logic hit_x;
  } hits_t;

endpackage

// File: src/mhd_lane.sv
// One axis: running average, deviation check and lockout counter.
module mhd_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic                                 first_i,
  input  logic signed [mhd_pkg::SampleW-1:0]   sample_i,
  input  mhd_pkg::lane_cfg_t                   cfg_i,
  output logic                                 hit_o
);

  logic signed [mhd_pkg::AvgW-1:0] avg_q, avg_d;
  logic [mhd_pkg::LockW-1:0]       cnt_q, cnt_d;

  logic signed [mhd_pkg::AvgW-1:0] sample_q16;
  logic signed [mhd_pkg::AvgW:0]   diff;
  logic [mhd_pkg::AvgW:0]          mag;
  logic [mhd_pkg::AvgW:0]          thr_q16;
  logic signed [mhd_pkg::WeightW:0] weight_s;
  logic signed [50:0]              prod;
  logic signed [50:0]              rnd;
  logic                            exceed;

  // Deviation of the sample from the average, in Q16.16
  assign sample_q16 = {sample_i, 16'h0000};
  assign diff       = {sample_q16[mhd_pkg::AvgW-1], sample_q16} - {avg_q[mhd_pkg::AvgW-1], avg_q};
  assign mag        = diff[mhd_pkg::AvgW] ? (mhd_pkg::AvgW+1)'(-diff) : (mhd_pkg::AvgW+1)'(diff);
  assign thr_q16    = {1'b0, cfg_i.threshold, 16'h0000};
  assign exceed     = mag > thr_q16;

  // Blend: avg + round(w * diff / 2^16)
  assign weight_s = {1'b0, cfg_i.weight};
  assign prod     = diff * weight_s;
  assign rnd      = prod + 51'sd32768;

  // Report a hit only when the axis is free
  assign hit_o = (cnt_q == '0) && exceed;

  always_comb begin
    cnt_d = cnt_q;
    avg_d = avg_q;
    if (accept_i) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - mhd_pkg::LockW'(1);
      end else if (exceed) begin
        cnt_d = cfg_i.lockout;
      end
      if (first_i) begin
        avg_d = sample_q16;
      end else begin
        avg_d = rnd[47:16] + avg_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
      cnt_q <= '0;
    end else begin
      avg_q <= avg_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: src/mhd_merge.sv
// Merges the lane hits into one result beat behind an output register and skid stage.
module mhd_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               hit_x_i,
  input  logic               hit_y_i,
  input  logic               hit_z_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mhd_pkg::hits_t     hits_o
);

  mhd_pkg::hits_t new_hits;
  mhd_pkg::hits_t out_q, out_d, skid_q, skid_d;
  logic           out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic           pop;

  // Combine the lanes
  assign new_hits = '{hit_z: hit_z_i, hit_y: hit_y_i, hit_x: hit_x_i};

  assign pop        = out_vld_q && out_ready_i;
  assign in_ready_o = !skid_vld_q;

  // Advance the output stage, park in the skid stage when stalled
  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (pop) begin
      out_vld_d = 1'b0;
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end
    end
    if (accept_i) begin
      if (!out_vld_d) begin
        out_d     = new_hits;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = new_hits;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign hits_o      = out_q;

endmodule

// File: src/three_axis_motion_hit_detector.sv
// Top level: configuration registers, three axis lanes and the result merge.
// Each result beat is held in the output register, or in the skid stage while the output is stalled.
// Throughput: one sample beat per cycle while input ready is high; each lane's average update and
//   deviation check finish in the accepting cycle.
// Input ready drops only when both the output register and the skid stage hold beats.
// Reset clears averages, lockout counters and the first-sample flag, and loads
//   threshold 3500, weight 65470 and lockout 20.
module three_axis_motion_hit_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mhd_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [mhd_pkg::CfgDataW-1:0]        cfg_data_i,
  // sample beats
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [mhd_pkg::SampleW-1:0]  accel_x_i,
  input  logic signed [mhd_pkg::SampleW-1:0]  accel_y_i,
  input  logic signed [mhd_pkg::SampleW-1:0]  accel_z_i,
  // result beats
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_x_o,
  output logic                                hit_y_o,
  output logic                                hit_z_o
);

  logic [mhd_pkg::ThrW-1:0]    thr_q;
  logic [mhd_pkg::WeightW-1:0] weight_q;
  logic [mhd_pkg::LockW-1:0]   lock_q;
  logic                        seen_q;
  logic                        accept;
  logic                        hit_x, hit_y, hit_z;
  mhd_pkg::lane_cfg_t          lane_cfg;
  mhd_pkg::hits_t              hits;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= mhd_pkg::ThrReset;
      weight_q <= mhd_pkg::WeightReset;
      lock_q   <= mhd_pkg::LockReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mhd_pkg::RegThreshold: thr_q    <= cfg_data_i[mhd_pkg::ThrW-1:0];
        mhd_pkg::RegWeight:    weight_q <= cfg_data_i[mhd_pkg::WeightW-1:0];
        mhd_pkg::RegLockout:   lock_q   <= cfg_data_i[mhd_pkg::LockW-1:0];
        default: ;
      endcase
    end
  end

  // Mark the first sample as taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (accept) begin
      seen_q <= 1'b1;
    end
  end

  // Saturate the weight to 1.0
  assign lane_cfg.threshold = thr_q;
  assign lane_cfg.weight    = (weight_q > mhd_pkg::WeightOne) ? mhd_pkg::WeightOne : weight_q;
  assign lane_cfg.lockout   = lock_q;

  mhd_lane u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .first_i  (!seen_q),
    .sample_i (accel_x_i),
    .cfg_i    (lane_cfg),
    .hit_o    (hit_x)
  );

  mhd_lane u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .first_i  (!seen_q),
    .sample_i (accel_y_i),
    .cfg_i    (lane_cfg),
    .hit_o    (hit_y)
  );

  mhd_lane u_lane_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .first_i  (!seen_q),
    .sample_i (accel_z_i),
    .cfg_i    (lane_cfg),
    .hit_o    (hit_z)
  );

  mhd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .hit_x_i     (hit_x),
    .hit_y_i     (hit_y),
    .hit_z_i     (hit_z),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hits_o      (hits)
  );

  assign hit_x_o = hits.hit_x;
  assign hit_y_o = hits.hit_y;
  assign hit_z_o = hits.hit_z;

endmodule
